// File: rtl/nmic_pkg.sv
// Shared types and constants of the nibble MCU instruction core.
`timescale 1ns / 1ps
`default_nettype none
package nmic_pkg;

  typedef enum logic [1:0] {
    MODE_EXEC  = 2'd0,
    MODE_IRQ   = 2'd1,
    MODE_TC    = 2'd2,
    MODE_RESET = 2'd3
  } mode_e;

  // flag_bits positions
  localparam int unsigned F_ST = 0;
  localparam int unsigned F_Z  = 1;
  localparam int unsigned F_C  = 2;
  localparam int unsigned F_V  = 3;
  localparam int unsigned F_S  = 4;
  localparam int unsigned F_N  = 5;

  // pending interrupt bits
  localparam int unsigned IRQ_SER = 0;
  localparam int unsigned IRQ_TMR = 1;
  localparam int unsigned IRQ_EXT = 2;

  // line latch bits
  localparam int unsigned L_TC  = 0;
  localparam int unsigned L_RST = 1;

  localparam logic [5:0] VEC_EXT = 6'h02;
  localparam logic [5:0] VEC_TMR = 6'h04;
  localparam logic [5:0] VEC_SER = 6'h06;

  localparam logic [1:0] SER_MODE_SHIFT = 2'b10;

  // first code of the direct-address exchange group (XD, then XYD)
  localparam logic [7:0] OP_XD = 8'h50;

  typedef struct packed {
    logic [3:0]       acc;
    logic [3:0]       x;
    logic [3:0]       y;
    logic [10:0]      pc;      // page in [10:6], offset in [5:0]
    logic [3:0][15:0] stack;
    logic [1:0]       sp;
    logic [5:0]       flags;
    logic [7:0]       pe;
    logic [7:0]       timer;
    logic [7:0]       presc;
    logic [3:0]       sshift;
    logic [7:0]       sbc;
    logic [2:0]       pend;
    logic [7:0]       olatch;
    logic [1:0]       lines;
  } state_t;

  localparam state_t STATE_RST = '{flags: 6'h01, default: '0};

  typedef struct packed {
    logic [10:0] next_address;
    logic [2:0]  cycles_used;
    logic        o_write;
    logic [7:0]  o_value;
    logic        p_write;
    logic [3:0]  p_value;
    logic        r_write;
    logic [1:0]  r_port;
    logic [3:0]  r_value;
    logic        status_flag;
    logic        interrupt_taken;
  } result_t;

endpackage
`default_nettype wire

// File: rtl/nmic_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
`default_nettype none
module nmic_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// File: rtl/nmic_exec.sv
// Single-pass instruction and event execution: next state and result of one transaction.
`timescale 1ns / 1ps
`default_nettype none
module nmic_exec #(
  parameter int unsigned TIMER_PRESCALE    = 32,
  parameter int unsigned SERIAL_STOP_COUNT = 8,
  parameter int unsigned PROGRAM_ADDR_BITS = 11
) (
  input  wire logic                    pla_i,
  input  wire nmic_pkg::state_t        state_i,
  input  wire logic [1:0]              mode_i,
  input  wire logic [7:0]              opcode_i,
  input  wire logic [7:0]              operand_i,
  input  wire logic [3:0]              k_i,
  input  wire logic [15:0]             r_ports_i,
  input  wire logic [1:0]              serial_i,
  input  wire logic [1:0]              level_i,
  input  wire logic [3:0]              ram_rdata_i,
  output nmic_pkg::state_t             state_o,
  output nmic_pkg::result_t            result_o,
  output logic                         ram_we_o,
  output logic [3:0]                   ram_wdata_o
);

  localparam logic [7:0] OP_NOP  = 8'h00, OP_OUTO = 8'h01, OP_OUTP = 8'h02, OP_OUT  = 8'h03;
  localparam logic [7:0] OP_TAY  = 8'h04, OP_TATH = 8'h05, OP_TATL = 8'h06, OP_TAS  = 8'h07;
  localparam logic [7:0] OP_ICY  = 8'h08, OP_ICM  = 8'h09, OP_STIC = 8'h0a, OP_XM   = 8'h0b;
  localparam logic [7:0] OP_ROL  = 8'h0c, OP_LM   = 8'h0d, OP_ADC  = 8'h0e, OP_AND  = 8'h0f;
  localparam logic [7:0] OP_DAA  = 8'h10, OP_DAS  = 8'h11, OP_INK  = 8'h12, OP_IN   = 8'h13;
  localparam logic [7:0] OP_TYA  = 8'h14, OP_TTHA = 8'h15, OP_TTLA = 8'h16, OP_TSA  = 8'h17;
  localparam logic [7:0] OP_DCY  = 8'h18, OP_DCM  = 8'h19, OP_STDC = 8'h1a, OP_XX   = 8'h1b;
  localparam logic [7:0] OP_ROR  = 8'h1c, OP_ST   = 8'h1d, OP_SBC  = 8'h1e, OP_OR   = 8'h1f;
  localparam logic [7:0] OP_SETR = 8'h20, OP_SETC = 8'h21, OP_RSTR = 8'h22, OP_RSTC = 8'h23;
  localparam logic [7:0] OP_TSTR = 8'h24, OP_TSTI = 8'h25, OP_TSTV = 8'h26, OP_TSTS = 8'h27;
  localparam logic [7:0] OP_TSTC = 8'h28, OP_TSTZ = 8'h29, OP_STS  = 8'h2a, OP_LS   = 8'h2b;
  localparam logic [7:0] OP_RTS  = 8'h2c, OP_NEG  = 8'h2d, OP_CM   = 8'h2e, OP_EOR  = 8'h2f;
  localparam logic [7:0] OP_SBIT = 8'h30, OP_RBIT = 8'h34, OP_TBIT = 8'h38, OP_RTI  = 8'h3c;
  localparam logic [7:0] OP_JPA  = 8'h3d, OP_EN   = 8'h3e, OP_DIS  = 8'h3f;
  localparam logic [7:0] OP_SETD = 8'h40, OP_RSTD = 8'h44, OP_TSTD = 8'h48, OP_TBA  = 8'h4c;
  localparam logic [7:0] OP_XD   = 8'h50, OP_XYD  = 8'h54, OP_LXI  = 8'h58, OP_CALL = 8'h60;
  localparam logic [7:0] OP_JMP  = 8'h68, OP_ADDI = 8'h70, OP_LYI  = 8'h80, OP_LI   = 8'h90;
  localparam logic [7:0] OP_CYI  = 8'ha0, OP_CI   = 8'hb0;

  localparam logic [9:0]  PRE1  = 10'(TIMER_PRESCALE);
  localparam logic [9:0]  PRE2  = 10'(2 * TIMER_PRESCALE);
  localparam logic [7:0]  STOP  = 8'(SERIAL_STOP_COUNT);
  localparam logic [10:0] PMASK = 11'((1 << PROGRAM_ADDR_BITS) - 1);

  always_comb begin
    nmic_pkg::state_t  n;
    nmic_pkg::result_t r;
    logic [7:0]  op;
    logic [3:0]  a, y, rd, bitm, rsel, t4;
    logic        cf, fst0, high;
    logic [4:0]  t5;
    logic [2:0]  oc, hit;
    logic [15:0] pv;
    logic [9:0]  tp;
    logic [1:0]  ninc;
    logic [8:0]  tsum;

    n      = state_i;
    r      = '0;
    op     = opcode_i;
    a      = state_i.acc;
    y      = state_i.y;
    rd     = ram_rdata_i;
    cf     = state_i.flags[nmic_pkg::F_C];
    fst0   = state_i.flags[nmic_pkg::F_ST];
    high   = (level_i != 2'd0);
    bitm   = 4'b0001 << op[1:0];
    rsel   = r_ports_i[{y[3:2], 2'b00} +: 4];
    t4     = '0;
    t5     = '0;
    oc     = '0;
    hit    = '0;
    pv     = '0;
    tp     = '0;
    ninc   = '0;
    tsum   = '0;
    ram_we_o    = 1'b0;
    ram_wdata_o = '0;

    case (nmic_pkg::mode_e'(mode_i))
      nmic_pkg::MODE_EXEC: begin
        if (!state_i.lines[nmic_pkg::L_RST]) begin
          oc   = 3'd1;
          n.pc = state_i.pc + 11'd1;
          case (op) inside
            OP_NOP: n.flags[nmic_pkg::F_ST] = 1'b1;
            OP_OUTO: begin
              if (pla_i) begin
                if (cf) n.olatch[7:4] = a;
                else    n.olatch[3:0] = a;
              end else begin
                n.olatch = {3'b000, cf, a};
              end
              r.o_write = 1'b1;
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
            OP_OUTP: begin
              r.p_write = 1'b1;
              r.p_value = a;
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
            OP_OUT: begin
              r.r_write = 1'b1;
              r.r_port  = y[1:0];
              r.r_value = a;
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
            OP_TAY: begin
              n.y = a;
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
            OP_TATH: begin
              n.timer[7:4] = a;
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
            OP_TATL: begin
              n.timer[3:0] = a;
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
            OP_TAS: begin
              n.sshift = a;
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
            OP_ICY, OP_STIC: begin
              if (op == OP_STIC) begin
                ram_we_o    = 1'b1;
                ram_wdata_o = a;
              end
              t5 = {1'b0, y} + 5'd1;
              n.y = t5[3:0];
              n.flags[nmic_pkg::F_ST] = ~t5[4];
              n.flags[nmic_pkg::F_Z]  = (t5[3:0] == 4'd0);
            end
            OP_ICM, OP_DCM: begin
              t5 = (op == OP_ICM) ? ({1'b0, rd} + 5'd1) : ({1'b0, rd} - 5'd1);
              ram_we_o    = 1'b1;
              ram_wdata_o = t5[3:0];
              n.flags[nmic_pkg::F_ST] = ~t5[4];
              n.flags[nmic_pkg::F_Z]  = (t5[3:0] == 4'd0);
            end
            OP_XM: begin
              ram_we_o    = 1'b1;
              ram_wdata_o = a;
              n.acc = rd;
              n.flags[nmic_pkg::F_Z]  = (rd == 4'd0);
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
            OP_ROL, OP_ADC, OP_SBC, OP_ADDI: begin
              case (op) inside
                OP_ROL:  t5 = {a, cf};
                OP_ADC:  t5 = {1'b0, rd} + {1'b0, a} + {4'd0, cf};
                OP_SBC:  t5 = {1'b0, rd} - {1'b0, a} - {4'd0, cf};
                default: t5 = {1'b0, op[3:0]} + {1'b0, a};
              endcase
              n.acc = t5[3:0];
              n.flags[nmic_pkg::F_ST] = ~t5[4];
              n.flags[nmic_pkg::F_C]  = t5[4];
              n.flags[nmic_pkg::F_Z]  = (t5[3:0] == 4'd0);
            end
            [OP_ADDI + 8'd1 : OP_ADDI + 8'd15]: begin
              t5 = {1'b0, op[3:0]} + {1'b0, a};
              n.acc = t5[3:0];
              n.flags[nmic_pkg::F_ST] = ~t5[4];
              n.flags[nmic_pkg::F_C]  = t5[4];
              n.flags[nmic_pkg::F_Z]  = (t5[3:0] == 4'd0);
            end
            OP_LM, OP_INK, OP_IN, OP_TYA, OP_TTHA, OP_TTLA, OP_TSA: begin
              case (op) inside
                OP_LM:   t4 = rd;
                OP_INK:  t4 = k_i;
                OP_IN:   t4 = r_ports_i[{y[1:0], 2'b00} +: 4];
                OP_TYA:  t4 = y;
                OP_TTHA: t4 = state_i.timer[7:4];
                OP_TTLA: t4 = state_i.timer[3:0];
                default: t4 = state_i.sshift;
              endcase
              n.acc = t4;
              n.flags[nmic_pkg::F_Z]  = (t4 == 4'd0);
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
            OP_AND, OP_OR: begin
              t4 = (op == OP_AND) ? (a & rd) : (a | rd);
              n.acc = t4;
              n.flags[nmic_pkg::F_Z]  = (t4 == 4'd0);
              n.flags[nmic_pkg::F_ST] = (t4 != 4'd0);
            end
            OP_DAA, OP_DAS: begin
              t5 = {1'b0, a};
              if (cf || a > 4'd9) begin
                t5 = {1'b0, a} + ((op == OP_DAA) ? 5'd6 : 5'd10);
              end
              n.acc = t5[3:0];
              n.flags[nmic_pkg::F_ST] = ~t5[4];
              n.flags[nmic_pkg::F_C]  = t5[4];
            end
            OP_DCY: begin
              t5 = {1'b0, y} - 5'd1;
              n.y = t5[3:0];
              n.flags[nmic_pkg::F_ST] = ~t5[4];
            end
            OP_STDC: begin
              ram_we_o    = 1'b1;
              ram_wdata_o = a;
              t5 = {1'b0, y} - 5'd1;
              n.y = t5[3:0];
              n.flags[nmic_pkg::F_ST] = ~t5[4];
              n.flags[nmic_pkg::F_Z]  = (t5[3:0] == 4'd0);
            end
            OP_XX: begin
              n.acc = state_i.x;
              n.x   = a;
              n.flags[nmic_pkg::F_Z]  = (state_i.x == 4'd0);
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
            OP_ROR: begin
              t4 = {cf, a[3:1]};
              n.acc = t4;
              n.flags[nmic_pkg::F_ST] = ~a[0];
              n.flags[nmic_pkg::F_C]  = a[0];
              n.flags[nmic_pkg::F_Z]  = (t4 == 4'd0);
            end
            OP_ST: begin
              ram_we_o    = 1'b1;
              ram_wdata_o = a;
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
            OP_SETR, OP_RSTR: begin
              r.r_write = 1'b1;
              r.r_port  = y[3:2];
              r.r_value = (op == OP_SETR) ? (rsel | (4'b0001 << y[1:0]))
                                          : (rsel & ~(4'b0001 << y[1:0]));
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
            OP_SETC, OP_RSTC: begin
              n.flags[nmic_pkg::F_C]  = (op == OP_SETC);
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
            OP_TSTR: n.flags[nmic_pkg::F_ST] = ~rsel[y[1:0]];
            OP_TSTI: n.flags[nmic_pkg::F_ST] = ~state_i.flags[nmic_pkg::F_N];
            OP_TSTV: begin
              n.flags[nmic_pkg::F_ST] = ~state_i.flags[nmic_pkg::F_V];
              n.flags[nmic_pkg::F_V]  = 1'b0;
            end
            OP_TSTS: begin
              n.flags[nmic_pkg::F_ST] = ~state_i.flags[nmic_pkg::F_S];
              if (state_i.flags[nmic_pkg::F_S]) n.sbc = '0;
              n.flags[nmic_pkg::F_S] = 1'b0;
            end
            OP_TSTC: n.flags[nmic_pkg::F_ST] = ~cf;
            OP_TSTZ: n.flags[nmic_pkg::F_ST] = ~state_i.flags[nmic_pkg::F_Z];
            OP_STS: begin
              ram_we_o    = 1'b1;
              ram_wdata_o = state_i.sshift;
              n.flags[nmic_pkg::F_Z]  = (state_i.sshift == 4'd0);
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
            OP_LS: begin
              n.sshift = rd;
              n.flags[nmic_pkg::F_Z]  = (rd == 4'd0);
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
            OP_RTS, OP_RTI: begin
              n.sp = state_i.sp - 2'd1;
              pv   = state_i.stack[n.sp];
              n.pc = pv[10:0];
              if (op == OP_RTI) begin
                n.flags[nmic_pkg::F_ST] = pv[13];
                n.flags[nmic_pkg::F_Z]  = pv[14];
                n.flags[nmic_pkg::F_C]  = pv[15];
              end else begin
                n.flags[nmic_pkg::F_ST] = 1'b1;
              end
            end
            OP_NEG: begin
              t4 = 4'd0 - a;
              n.acc = t4;
              n.flags[nmic_pkg::F_ST] = (t4 != 4'd0);
            end
            OP_CM: begin
              t5 = {1'b0, rd} - {1'b0, a};
              n.flags[nmic_pkg::F_C]  = t5[4];
              n.flags[nmic_pkg::F_ST] = (t5[3:0] != 4'd0);
              n.flags[nmic_pkg::F_Z]  = (t5[3:0] == 4'd0);
            end
            OP_EOR: begin
              t4 = a ^ rd;
              n.acc = t4;
              n.flags[nmic_pkg::F_ST] = (t4 != 4'd0);
              n.flags[nmic_pkg::F_Z]  = (t4 == 4'd0);
            end
            [OP_SBIT : OP_SBIT + 8'd3]: begin
              ram_we_o    = 1'b1;
              ram_wdata_o = rd | bitm;
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
            [OP_RBIT : OP_RBIT + 8'd3]: begin
              ram_we_o    = 1'b1;
              ram_wdata_o = rd & ~bitm;
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
            [OP_TBIT : OP_TBIT + 8'd3]: n.flags[nmic_pkg::F_ST] = ((rd & bitm) == 4'd0);
            OP_JPA: begin
              n.pc = {operand_i[4:0], a, 2'b00};
              oc   = 3'd2;
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
            OP_EN, OP_DIS: begin
              n.pe = (op == OP_EN) ? (state_i.pe | operand_i) : (state_i.pe & ~operand_i);
              n.pc = state_i.pc + 11'd2;
              oc   = 3'd2;
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
            [OP_SETD : OP_SETD + 8'd3], [OP_RSTD : OP_RSTD + 8'd3]: begin
              r.r_write = 1'b1;
              r.r_port  = 2'd0;
              r.r_value = (op < OP_RSTD) ? (r_ports_i[3:0] | bitm) : (r_ports_i[3:0] & ~bitm);
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
            [OP_TSTD : OP_TSTD + 8'd3]:
              n.flags[nmic_pkg::F_ST] = ((r_ports_i[11:8] & bitm) == 4'd0);
            [OP_TBA : OP_TBA + 8'd3]: n.flags[nmic_pkg::F_ST] = ((a & bitm) == 4'd0);
            [OP_XD : OP_XD + 8'd3]: begin
              ram_we_o    = 1'b1;
              ram_wdata_o = a;
              n.acc = rd;
              n.flags[nmic_pkg::F_Z]  = (rd == 4'd0);
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
            [OP_XYD : OP_XYD + 8'd3]: begin
              ram_we_o    = 1'b1;
              ram_wdata_o = y;
              n.y = rd;
              n.flags[nmic_pkg::F_Z]  = (rd == 4'd0);
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
            [OP_LXI : OP_LXI + 8'd7]: begin
              n.x = {1'b0, op[2:0]};
              n.flags[nmic_pkg::F_Z]  = (op[2:0] == 3'd0);
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
            [OP_CALL : OP_JMP + 8'd7]: begin
              n.pc = state_i.pc + 11'd2;
              oc   = 3'd2;
              if (fst0) begin
                if (op < OP_JMP) begin
                  n.stack[n.sp] = {5'd0, n.pc};
                  n.sp          = n.sp + 2'd1;
                end
                n.pc = {op[2:0], operand_i};
              end
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
            [OP_LYI : OP_LI + 8'd15]: begin
              if (op < OP_LI) n.y   = op[3:0];
              else            n.acc = op[3:0];
              n.flags[nmic_pkg::F_Z]  = (op[3:0] == 4'd0);
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
            [OP_CYI : OP_CI + 8'd15]: begin
              t5 = {1'b0, op[3:0]} - {1'b0, (op < OP_CI) ? y : a};
              n.flags[nmic_pkg::F_C]  = t5[4];
              n.flags[nmic_pkg::F_ST] = (t5[3:0] != 4'd0);
              n.flags[nmic_pkg::F_Z]  = (t5[3:0] == 4'd0);
            end
            default: begin
              // short jump within the page, taken on status set
              if (fst0) n.pc[5:0] = op[5:0];
              n.flags[nmic_pkg::F_ST] = 1'b1;
            end
          endcase

          // internal timer: at most two prescaler wraps per instruction
          if (n.pe[7]) begin
            tp = {2'b00, n.presc} + {7'd0, oc};
            if (tp >= PRE2) begin
              ninc = 2'd2;
              tp   = tp - PRE2;
            end else if (tp >= PRE1) begin
              ninc = 2'd1;
              tp   = tp - PRE1;
            end
            n.presc = tp[7:0];
            tsum    = {1'b0, n.timer} + {7'd0, ninc};
            n.timer = tsum[7:0];
            if (tsum[8]) begin
              n.flags[nmic_pkg::F_V]         = 1'b1;
              n.pend[nmic_pkg::IRQ_TMR]      = 1'b1;
            end
          end

          if (n.pe[5:4] == nmic_pkg::SER_MODE_SHIFT) begin
            for (int i = 0; i < 2; i++) begin
              if (3'(i) < oc) begin
                n.sbc = n.sbc + 8'd1;
                if (n.sbc < STOP && !n.flags[nmic_pkg::F_S]) begin
                  n.sshift = {serial_i[i], n.sshift[3:1]};
                  if (n.sbc >= 8'd4) begin
                    n.flags[nmic_pkg::F_S]    = 1'b1;
                    n.pend[nmic_pkg::IRQ_SER] = 1'b1;
                  end
                end
              end
            end
          end

          hit = n.pend & n.pe[2:0];
          if (hit != 3'd0) begin
            n.stack[n.sp] = {n.flags[nmic_pkg::F_C], n.flags[nmic_pkg::F_Z],
                             n.flags[nmic_pkg::F_ST], 2'b00, n.pc};
            n.sp = n.sp + 2'd1;
            if (hit[nmic_pkg::IRQ_EXT])      n.pc = {5'd0, nmic_pkg::VEC_EXT};
            else if (hit[nmic_pkg::IRQ_TMR]) n.pc = {5'd0, nmic_pkg::VEC_TMR};
            else                             n.pc = {5'd0, nmic_pkg::VEC_SER};
            n.flags[nmic_pkg::F_ST] = 1'b1;
            n.pend = '0;
            r.interrupt_taken = 1'b1;
            oc = oc + 3'd3;
          end
        end
      end
      nmic_pkg::MODE_IRQ: begin
        if (state_i.pe[nmic_pkg::IRQ_EXT] && !state_i.flags[nmic_pkg::F_N] && high) begin
          n.pend[nmic_pkg::IRQ_EXT] = 1'b1;
        end
        // a pulse sets the request but leaves the line low
        n.flags[nmic_pkg::F_N] = high && (level_i != 2'd2);
      end
      nmic_pkg::MODE_TC: begin
        if (state_i.lines[nmic_pkg::L_TC] && !high && state_i.pe[6]) begin
          tsum    = {1'b0, state_i.timer} + 9'd1;
          n.timer = tsum[7:0];
          if (tsum[8]) begin
            n.flags[nmic_pkg::F_V]    = 1'b1;
            n.pend[nmic_pkg::IRQ_TMR] = 1'b1;
          end
        end
        n.lines[nmic_pkg::L_TC] = high;
      end
      default: begin
        if (state_i.lines[nmic_pkg::L_RST] && !high) n = nmic_pkg::STATE_RST;
        n.lines[nmic_pkg::L_RST] = high;
      end
    endcase

    r.next_address = n.pc & PMASK;
    r.cycles_used  = oc;
    r.o_value      = n.olatch;
    r.status_flag  = n.flags[nmic_pkg::F_ST];
    state_o  = n;
    result_o = r;
  end

endmodule
`default_nettype wire

// File: rtl/nibble_mcu_instruction_core.sv
// Top level of the nibble MCU instruction core: input stage, data RAM, state and result register.
//
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_stall_o   mode, opcode, operand, k_in, r_ports_in,
//                                               serial_in_bits, line_level
// out      output     out_valid_o / out_stall_i next_address .. interrupt_taken
// cfg      input      cfg_valid_i / cfg_ready_o pla_eight_bit (cfg_data_i)
//
// One transaction per cycle while the output is not stalled; each passes the input register, then the
// execute logic into the result register. The data RAM read is issued as a transaction
// is taken, with X/Y forwarded from the instruction executing in the same cycle.
// Reset needs no RAM sweep: per-entry valid bits make unwritten words read as zero.
// A stalled result holds the input stage; the input stage still takes a transaction
// while empty or while its occupant moves on.
`timescale 1ns / 1ps
`default_nettype none
module nibble_mcu_instruction_core #(
  parameter int unsigned DATA_ADDR_BITS    = 7,
  parameter int unsigned PROGRAM_ADDR_BITS = 11,
  parameter int unsigned TIMER_PRESCALE    = 32,
  parameter int unsigned SERIAL_STOP_COUNT = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [7:0]  opcode_i,
  input  wire logic [7:0]  operand_i,
  input  wire logic [3:0]  k_in_i,
  input  wire logic [15:0] r_ports_in_i,
  input  wire logic [1:0]  serial_in_bits_i,
  input  wire logic [1:0]  line_level_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [10:0]      next_address_o,
  output logic [2:0]       cycles_used_o,
  output logic             o_write_o,
  output logic [7:0]       o_value_o,
  output logic             p_write_o,
  output logic [3:0]       p_value_o,
  output logic             r_write_o,
  output logic [1:0]       r_port_o,
  output logic [3:0]       r_value_o,
  output logic             status_flag_o,
  output logic             interrupt_taken_o
);

  localparam int unsigned AW    = DATA_ADDR_BITS;
  localparam int unsigned DEPTH = 1 << DATA_ADDR_BITS;

  logic pla_q;

  logic        in_valid_q;
  logic [1:0]  mode_q, level_q, serial_q;
  logic [7:0]  opcode_q, operand_q;
  logic [3:0]  k_q;
  logic [15:0] rports_q;
  logic [AW-1:0] addr_q;

  nmic_pkg::state_t  state_q, state_d;
  nmic_pkg::result_t res_d, res_q;
  logic              out_valid_q;

  logic          adv, exec_fire, in_accept;
  logic          ram_we, exec_we;
  logic [3:0]    exec_wdata, ram_rdata, rdata_eff;
  logic [AW-1:0] raddr;
  logic [3:0]    x_fwd, y_fwd;
  logic [DEPTH-1:0] vld_q;
  logic          rd_vld_q, byp_hit_q;
  logic [3:0]    byp_data_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pla_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pla_q <= cfg_data_i;
    end
  end

  assign adv        = !out_valid_q || !out_stall_i;
  assign exec_fire  = in_valid_q && adv;
  assign in_stall_o = in_valid_q && !adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign x_fwd = exec_fire ? state_d.x : state_q.x;
  assign y_fwd = exec_fire ? state_d.y : state_q.y;
  // direct-address exchanges use the low opcode bits, everything else X:Y
  assign raddr = (opcode_i[7:3] == nmic_pkg::OP_XD[7:3]) ? AW'(opcode_i[2:0])
                                                          : AW'({x_fwd, y_fwd});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (exec_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q     <= mode_i;
      opcode_q   <= opcode_i;
      operand_q  <= operand_i;
      k_q        <= k_in_i;
      rports_q   <= r_ports_in_i;
      serial_q   <= serial_in_bits_i;
      level_q    <= line_level_i;
      addr_q     <= raddr;
      rd_vld_q   <= vld_q[raddr];
      byp_hit_q  <= ram_we && (addr_q == raddr);
      byp_data_q <= exec_wdata;
    end
  end

  assign ram_we    = exec_fire && exec_we;
  assign rdata_eff = byp_hit_q ? byp_data_q : (rd_vld_q ? ram_rdata : 4'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (ram_we) begin
      vld_q[addr_q] <= 1'b1;
    end
  end

  nmic_ram #(
    .WIDTH(4),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(addr_q),
    .wdata_i(exec_wdata),
    .re_i   (in_accept),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  nmic_exec #(
    .TIMER_PRESCALE   (TIMER_PRESCALE),
    .SERIAL_STOP_COUNT(SERIAL_STOP_COUNT),
    .PROGRAM_ADDR_BITS(PROGRAM_ADDR_BITS)
  ) u_exec (
    .pla_i      (pla_q),
    .state_i    (state_q),
    .mode_i     (mode_q),
    .opcode_i   (opcode_q),
    .operand_i  (operand_q),
    .k_i        (k_q),
    .r_ports_i  (rports_q),
    .serial_i   (serial_q),
    .level_i    (level_q),
    .ram_rdata_i(rdata_eff),
    .state_o    (state_d),
    .result_o   (res_d),
    .ram_we_o   (exec_we),
    .ram_wdata_o(exec_wdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= nmic_pkg::STATE_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (exec_fire) state_q <= state_d;
      if (adv) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign next_address_o    = res_q.next_address;
  assign cycles_used_o     = res_q.cycles_used;
  assign o_write_o         = res_q.o_write;
  assign o_value_o         = res_q.o_value;
  assign p_write_o         = res_q.p_write;
  assign p_value_o         = res_q.p_value;
  assign r_write_o         = res_q.r_write;
  assign r_port_o          = res_q.r_port;
  assign r_value_o         = res_q.r_value;
  assign status_flag_o     = res_q.status_flag;
  assign interrupt_taken_o = res_q.interrupt_taken;

endmodule
`default_nettype wire
